@@ src/kte_pkg.sv @@
// ----------------------------------------------------------------------------
// kte_pkg - shared types, constants and tables of the tilt estimator
// widths, calibration matrix, cordic angle table and helper types
// ----------------------------------------------------------------------------
package kte_pkg;

    localparam int NUM_AXES_DEF     = 3;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;
    localparam int NUM_REGS         = 7;

    localparam logic [2:0] REG_PROCESS_NOISE  = 3'd0;
    localparam logic [2:0] REG_MEAS_NOISE     = 3'd1;
    localparam logic [2:0] REG_INIT_COV       = 3'd2;
    localparam logic [2:0] REG_INIT_Z         = 3'd3;
    localparam logic [2:0] REG_OFFSET_X       = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y       = 3'd5;
    localparam logic [2:0] REG_OFFSET_Z       = 3'd6;

    localparam logic [15:0] RST_PROCESS_NOISE = 16'd26;
    localparam logic [15:0] RST_MEAS_NOISE    = 16'd512;
    localparam logic [15:0] RST_INIT_COV      = 16'd512;
    localparam logic [15:0] RST_INIT_Z        = 16'd1000;
    localparam logic [15:0] RST_OFFSET_X      = 16'd35;
    localparam logic [15:0] RST_OFFSET_Y      = 16'd27;
    localparam logic [15:0] RST_OFFSET_Z      = 16'hFF29;

    localparam logic signed [23:0] EST_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] EST_MIN = 24'sh800000;

    // lane command from the top level
    typedef struct packed {
        logic        start;
        logic [15:0] gain;
    } lane_cmd_t;

    // calibration matrix, scaled by 2^20, indexed [row j][column i]
    function automatic logic signed [21:0] cal_coef(input logic [1:0] j,
                                                    input logic [1:0] i);
        logic signed [21:0] c;
        c = '0;
        case ({j, i})
            4'b0000: c = 22'sd1046957;
            4'b0001: c = -22'sd19562;
            4'b0010: c = -22'sd33;
            4'b0100: c = -22'sd33037;
            4'b0101: c = 22'sd1074001;
            4'b0110: c = -22'sd4705;
            4'b1000: c = -22'sd6634;
            4'b1001: c = -22'sd1221;
            4'b1010: c = 22'sd1034431;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [29:0] atan_entry(input logic [4:0] i);
        logic [29:0] a;
        a = '0;
        case (i)
            5'd0:  a = 30'd294912000;
            5'd1:  a = 30'd174096719;
            5'd2:  a = 30'd91987925;
            5'd3:  a = 30'd46694507;
            5'd4:  a = 30'd23437865;
            5'd5:  a = 30'd11730358;
            5'd6:  a = 30'd5866610;
            5'd7:  a = 30'd2933484;
            5'd8:  a = 30'd1466764;
            5'd9:  a = 30'd733385;
            5'd10: a = 30'd366693;
            5'd11: a = 30'd183346;
            5'd12: a = 30'd91673;
            5'd13: a = 30'd45837;
            5'd14: a = 30'd22918;
            5'd15: a = 30'd11459;
            5'd16: a = 30'd5730;
            5'd17: a = 30'd2865;
            5'd18: a = 30'd1432;
            5'd19: a = 30'd716;
            5'd20: a = 30'd358;
            5'd21: a = 30'd179;
            5'd22: a = 30'd90;
            5'd23: a = 30'd45;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ src/kte_gain_div.sv @@
// ----------------------------------------------------------------------------
// kte_gain_div - restoring divider for the kalman gain
// k = (p' << 16) / (p' + r), one quotient bit per cycle, saturated
// ----------------------------------------------------------------------------
module kte_gain_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [24:0] pp,
    input  logic [25:0] den,
    output logic        done,
    output logic [15:0] gain
);

    logic [4:0]  cnt_reg,  cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [25:0] rem_reg,  rem_next;
    logic [16:0] quo_reg,  quo_next;
    logic [25:0] den_reg,  den_next;
    logic        zero_reg, zero_next;
    logic [26:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        trial     = '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            // pp <= den, so the integer quotient bit is 0 or 1
            den_next  = den;
            zero_next = (den == '0);
            if ({1'b0, pp} >= den && den != '0)
            begin
                rem_next = {1'b0, pp} - den;
                quo_next = 17'd1;
            end
            else
            begin
                rem_next = {1'b0, pp};
                quo_next = '0;
            end
        end
        else if (busy_reg)
        begin
            trial = {rem_reg, 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 26'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = trial[25:0];
                quo_next = {quo_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // done is high once the last quotient bit is registered
    assign done = done_reg;

    always_comb
    begin
        if (zero_reg)
            gain = '0;
        else if (quo_reg[16])
            gain = 16'hFFFF;
        else
            gain = quo_reg[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        zero_reg <= zero_next;
    end

endmodule

@@ src/kte_axis_lane.sv @@
// ----------------------------------------------------------------------------
// kte_axis_lane - scalar kalman estimate update (or raw copy) for one axis
// filtered: two stages, multiply gain by innovation, then round, add, clamp
// ----------------------------------------------------------------------------
module kte_axis_lane
#(
    parameter bit                 FILTERED  = 1'b1,
    parameter logic signed [23:0] RST_VALUE = '0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  kte_pkg::lane_cmd_t     cmd,
    input  logic signed [15:0]     sample,
    input  logic                   load,
    input  logic signed [23:0]     load_value,
    output logic signed [23:0]     estimate
);

    localparam logic signed [23:0] EST_MAX_L = kte_pkg::EST_MAX;
    localparam logic signed [23:0] EST_MIN_L = kte_pkg::EST_MIN;

    logic signed [23:0] est_reg;
    logic signed [24:0] diff;
    logic signed [41:0] prod_reg;
    logic               stage_reg;
    logic signed [42:0] sum;
    logic signed [23:0] meas;

    assign meas = {sample, 8'd0};
    assign diff = 25'(meas) - 25'(est_reg);
    assign sum  = 43'(est_reg) + 43'((prod_reg + 42'sd32768) >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_reg <= 1'b0;
        else
            stage_reg <= cmd.start;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            prod_reg <= $signed({1'b0, cmd.gain}) * diff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            est_reg <= RST_VALUE;
        else if (load)
            est_reg <= load_value;
        else if (cmd.start && !FILTERED)
            est_reg <= meas;
        else if (stage_reg && FILTERED)
        begin
            if (sum > 43'(EST_MAX_L))
                est_reg <= EST_MAX_L;
            else if (sum < 43'(EST_MIN_L))
                est_reg <= EST_MIN_L;
            else
                est_reg <= sum[23:0];
        end
    end

    assign estimate = est_reg;

endmodule

@@ src/kte_cordic.sv @@
// ----------------------------------------------------------------------------
// kte_cordic - iterative vectoring cordic, atan2 in centidegrees
// one micro-rotation per cycle
// ----------------------------------------------------------------------------
module kte_cordic
#(
    parameter int CORDIC_STEPS = kte_pkg::CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] y_in,
    input  logic signed [31:0] x_in,
    output logic               done,
    output logic signed [15:0] angle
);

    localparam int STEPS = (CORDIC_STEPS < kte_pkg::TABLE_LEN) ?
                           CORDIC_STEPS : kte_pkg::TABLE_LEN;

    logic               busy_reg;
    logic [4:0]         i_reg;
    logic signed [44:0] x_reg, y_reg;
    logic signed [35:0] z_reg;
    logic signed [15:0] base_reg;
    logic               zero_reg;
    logic signed [44:0] xs, ys, x0, y0;
    logic signed [36:0] zr;
    logic signed [20:0] fin;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign x0 = x_in[31] ? -(45'(x_in) <<< 8) : (45'(x_in) <<< 8);
    assign y0 = x_in[31] ? -(45'(y_in) <<< 8) : (45'(y_in) <<< 8);
    assign zr = (37'(z_reg) + 37'sd32768) >>> 16;
    assign fin = 21'(base_reg) + 21'(zr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && i_reg == 5'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done     <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            i_reg    <= '0;
            zero_reg <= (x_in == '0) && (y_in == '0);
            base_reg <= x_in[31] ? (y_in[31] ? -16'sd18000 : 16'sd18000) : 16'sd0;
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= '0;
        end
        else if (busy_reg)
        begin
            i_reg <= i_reg + 5'd1;
            if (!y_reg[44])
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + 36'(kte_pkg::atan_entry(i_reg));
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - 36'(kte_pkg::atan_entry(i_reg));
            end
        end
    end

    always_comb
    begin
        if (zero_reg)
            angle = '0;
        else if (fin > 21'sd18000)
            angle = 16'sd18000;
        else if (fin < -21'sd18000)
            angle = -16'sd18000;
        else
            angle = fin[15:0];
    end

endmodule

@@ src/kalman_tilt_estimator_top.sv @@
// ----------------------------------------------------------------------------
// kalman_tilt_estimator_top - kalman-filtered accelerometer tilt estimator
// per-axis scalar kalman filter, calibration and cordic pitch/roll
// ----------------------------------------------------------------------------
// One item is one three-axis sample in mg. The block takes it, computes the
// shared kalman gain in a bit-serial divider, updates the three axis lanes
// in parallel, applies the calibration matrix with one multiplier (each
// column seeds the accumulator with its offset, then adds three products),
// then runs pitch and roll in two cordic units side by side. One item is in
// work at a time, so a new item is taken only once the last result has been
// moved to the output register. The result sits in an output register, so
// the next item is taken while the result waits.
// Config writes to initial_covariance and initial_z_estimate reload state.
module kalman_tilt_estimator_top
#(
    parameter int NUM_AXES     = kte_pkg::NUM_AXES_DEF,
    parameter int CORDIC_STEPS = kte_pkg::CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items: accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    // results: filtered_x, filtered_y, filtered_z, pitch_angle, roll_angle
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_LANE = 3'd2;
    localparam logic [2:0] ST_CAL  = 3'd3;
    localparam logic [2:0] ST_ANG  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]  state_reg;
    logic [15:0] q_reg, r_reg, offx_reg, offy_reg, offz_reg;
    logic [23:0] cov_reg;
    logic [47:0] sample_reg;
    logic [24:0] pp;
    logic [25:0] den;
    logic        div_done;
    logic [15:0] gain;
    logic [3:0]  lane_cnt_reg;
    logic        in_acc;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign pp  = 25'(cov_reg) + 25'({q_reg, 8'd0});
    assign den = 26'(pp) + 26'({r_reg, 8'd0});

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg     <= kte_pkg::RST_PROCESS_NOISE;
            r_reg     <= kte_pkg::RST_MEAS_NOISE;
            offx_reg  <= kte_pkg::RST_OFFSET_X;
            offy_reg  <= kte_pkg::RST_OFFSET_Y;
            offz_reg  <= kte_pkg::RST_OFFSET_Z;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kte_pkg::REG_PROCESS_NOISE: q_reg     <= cfg_data;
                kte_pkg::REG_MEAS_NOISE:    r_reg     <= cfg_data;
                // these two only reload state, see below
                kte_pkg::REG_INIT_COV:      ;
                kte_pkg::REG_INIT_Z:        ;
                kte_pkg::REG_OFFSET_X:      offx_reg  <= cfg_data;
                kte_pkg::REG_OFFSET_Y:      offy_reg  <= cfg_data;
                kte_pkg::REG_OFFSET_Z:      offz_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // shared gain divider
    kte_gain_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_acc),
        .pp    (pp),
        .den   (den),
        .done  (div_done),
        .gain  (gain)
    );

    // covariance update: one 17x25 multiply, rounded, clamped
    logic [41:0] np_full;
    logic [25:0] np;
    assign np_full = 42'({1'b0, 17'd65536} - 18'(gain)) * 42'(pp);
    assign np      = 26'((np_full + 42'd32768) >> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cov_reg <= {kte_pkg::RST_INIT_COV, 8'd0};
        else if (cfg_we && cfg_index == kte_pkg::REG_INIT_COV)
            cov_reg <= {cfg_data, 8'd0};
        else if (div_done)
            cov_reg <= (np > 26'hFFFFFF) ? 24'hFFFFFF : np[23:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            sample_reg <= s_axis_tdata;
    end

    // axis lanes
    kte_pkg::lane_cmd_t lane_cmd;
    logic signed [23:0] est [3];
    logic               zload;

    assign lane_cmd.start = div_done;
    assign lane_cmd.gain  = gain;
    assign zload = cfg_we && cfg_index == kte_pkg::REG_INIT_Z;

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            kte_axis_lane
            #(
                .FILTERED  (g < NUM_AXES),
                .RST_VALUE ((g == 2) ? 24'({kte_pkg::RST_INIT_Z, 8'd0}) : 24'sd0)
            ) u_lane
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (lane_cmd),
                .sample     (sample_reg[16*g +: 16]),
                .load       ((g == 2) ? zload : 1'b0),
                .load_value ((g == 2) ? {cfg_data, 8'd0} : 24'sd0),
                .estimate   (est[g])
            );
        end
    endgenerate

    // calibration merge: serial multiply-accumulate, column i, row j
    logic [1:0]         ci_reg, rj_reg;
    logic signed [45:0] acc_reg;
    logic signed [31:0] norm_reg [3];
    logic signed [45:0] prod;
    logic signed [15:0] offs;
    logic signed [45:0] accn;
    logic signed [45:0] accn_sh;

    assign prod = 46'(est[rj_reg]) * 46'(kte_pkg::cal_coef(rj_reg, ci_reg));
    always_comb
    begin
        case (ci_reg)
            2'd0:    offs = offx_reg;
            2'd1:    offs = offy_reg;
            default: offs = offz_reg;
        endcase
    end
    assign accn = acc_reg + prod;
    assign accn_sh = (accn + 46'sd8388608) >>> 24;

    // output register
    logic signed [15:0] fx, fy, fz;
    logic               cor_start, cor_done0, cor_done1;
    logic signed [15:0] pitch, roll;

    function automatic logic signed [15:0] sat_mg(input logic signed [23:0] e);
        logic signed [24:0] t;
        t = (25'(e) + 25'sd128) >>> 8;
        return (t > 25'sd32767) ? 16'sh7FFF : (t < -25'sd32768 ? 16'sh8000 : t[15:0]);
    endfunction

    assign fx = sat_mg(est[0]);
    assign fy = sat_mg(est[1]);
    assign fz = sat_mg(est[2]);
    assign cor_start = (state_reg == ST_CAL) && ci_reg == 2'd2 && rj_reg == 2'd2
                       && lane_cnt_reg == 4'd1;

    kte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch
    (
        .clk(clk), .rst_n(rst_n), .start(cor_start),
        .y_in(norm_reg[0]), .x_in(32'(accn_sh)),
        .done(cor_done0), .angle(pitch)
    );
    kte_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll
    (
        .clk(clk), .rst_n(rst_n), .start(cor_start),
        .y_in(norm_reg[1]), .x_in(32'(accn_sh)),
        .done(cor_done1), .angle(roll)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_axis_tvalid <= 1'b0;
            lane_cnt_reg  <= '0;
            ci_reg        <= '0;
            rj_reg        <= '0;
        end
        else
        begin
            // a new result may replace one that leaves in the same cycle
            if (state_reg == ST_OUT && (!m_axis_tvalid || m_axis_tready))
                m_axis_tvalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                m_axis_tvalid <= 1'b0;
            case (state_reg)
                ST_IDLE: if (in_acc) state_reg <= ST_DIV;
                ST_DIV:
                    if (div_done)
                    begin
                        state_reg    <= ST_LANE;
                        lane_cnt_reg <= '0;
                    end
                ST_LANE:
                begin
                    lane_cnt_reg <= lane_cnt_reg + 4'd1;
                    if (lane_cnt_reg == 4'd1)
                    begin
                        state_reg    <= ST_CAL;
                        ci_reg       <= '0;
                        rj_reg       <= '0;
                        lane_cnt_reg <= '0;
                    end
                end
                ST_CAL:
                begin
                    // first cycle of each column's run only seeds the accumulator
                    if (lane_cnt_reg == 4'd0)
                        lane_cnt_reg <= 4'd1;
                    else if (rj_reg == 2'd2)
                    begin
                        rj_reg       <= '0;
                        lane_cnt_reg <= 4'd0;
                        if (ci_reg == 2'd2)
                            state_reg <= ST_ANG;
                        else
                            ci_reg <= ci_reg + 2'd1;
                    end
                    else
                        rj_reg <= rj_reg + 2'd1;
                end
                ST_ANG: if (cor_done0) state_reg <= ST_OUT;
                ST_OUT:
                    if (!m_axis_tvalid || m_axis_tready)
                        state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    logic signed [15:0] pitch_reg, roll_reg;
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CAL)
        begin
            if (lane_cnt_reg == 4'd0)
                acc_reg <= 46'(offs) <<< 24;
            else
            begin
                acc_reg <= accn;
                if (rj_reg == 2'd2)
                    norm_reg[ci_reg] <= 32'(accn_sh);
            end
        end
        if (cor_done0 && cor_done1)
        begin
            pitch_reg <= pitch;
            roll_reg  <= roll;
        end
        if (state_reg == ST_OUT && (!m_axis_tvalid || m_axis_tready))
            m_axis_tdata <= {roll_reg, pitch_reg, fz, fy, fx};
    end

endmodule
